// ===== sv/vsef_pkg.sv =====
// ----------------------------------------------------------------------------
// vsef_pkg: shared types and constants for the vertical Sobel edge filter
// Line store geometry, register indexes, the front-to-back work word and the
// clamped gradient function.
// ----------------------------------------------------------------------------
package vsef_pkg;

   localparam int LINE_WIDTH  = 512;
   localparam int COL_W       = $clog2(LINE_WIDTH);
   localparam int DIM_W       = 10;
   localparam int PIX_W       = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int WIDTH_RESET = (512 < LINE_WIDTH) ? 512 : LINE_WIDTH;

   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(512);
   localparam logic [PIX_W-1:0] PIXEL_MAX    = {PIX_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] al;
      logic [PIX_W-1:0] ac;
      logic [PIX_W-1:0] ar;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] bc;
      logic [PIX_W-1:0] br;
      logic             emit_mid;
      logic             emit_end;
      logic             end_frame;
   } work_item_type;

   function automatic logic [PIX_W-1:0] sobel_grad(
      input logic [PIX_W-1:0] al, input logic [PIX_W-1:0] ac, input logic [PIX_W-1:0] ar,
      input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] bc, input logic [PIX_W-1:0] br);
      logic [PIX_W+1:0] sum_a;
      logic [PIX_W+1:0] sum_b;
      logic [PIX_W+2:0] diff;
      logic [PIX_W-1:0] res;
      sum_a = (PIX_W+2)'(al) + (PIX_W+2)'({ac, 1'b0}) + (PIX_W+2)'(ar);
      sum_b = (PIX_W+2)'(bl) + (PIX_W+2)'({bc, 1'b0}) + (PIX_W+2)'(br);
      diff  = (PIX_W+3)'(sum_b) - (PIX_W+3)'(sum_a);
      if (diff[PIX_W+2]) begin
         res = '0;
      end else if (diff[PIX_W+1:PIX_W] != 2'b00) begin
         res = PIXEL_MAX;
      end else begin
         res = diff[PIX_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/vsef_front.sv =====
// ----------------------------------------------------------------------------
// vsef_front: pixel intake, raster position and line store
// Tracks column and row, keeps the two previous rows in a line memory, builds
// the 3x2 neighborhood for each pixel and queues those that produce results.
// ----------------------------------------------------------------------------
module vsef_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vsef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsef_pkg::DIM_W-1:0]      csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vsef_pkg::PIX_W-1:0]      req_tdata,
   output vsef_pkg::work_item_type         q_item,
   output logic                            q_push,
   input  logic                            q_full
);
   import vsef_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] above;
   } line_entry_type;

   typedef struct packed {
      logic flush;
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic col_last;
   } pos_type;

   line_entry_type   line_mem [LINE_WIDTH];

   logic [COL_W:0]   width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff;
   logic [DIM_W-1:0] row_ff;

   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   pos_type          s1_pos_ff;
   line_entry_type   rd_ff;
   logic             byp_ff;
   line_entry_type   byp_data_ff;

   logic [PIX_W-1:0] bw0_ff, bw1_ff, aw0_ff, aw1_ff;

   pos_type          pos_in;
   logic             req_acc;
   logic             s1_emits;
   logic             s1_go;
   line_entry_type   rd_entry;
   line_entry_type   wr_entry;
   logic [PIX_W-1:0] cb, ca;
   logic [COL_W:0]   width_in;
   logic [DIM_W-1:0] height_in;

   always_comb begin
      pos_in.flush    = (row_ff == height_ff);
      pos_in.row_ge1  = (row_ff != '0);
      pos_in.row_ge2  = (row_ff[DIM_W-1:1] != '0);
      pos_in.col_ge1  = (col_ff != '0);
      pos_in.col_ge2  = (col_ff[COL_W-1:1] != '0);
      pos_in.col_last = (((COL_W+1)'(col_ff) + (COL_W+1)'(1)) == width_ff);
   end

   always_comb begin
      if (csr_wdata == '0) begin
         width_in = (COL_W+1)'(1);
      end else if (int'(csr_wdata) > LINE_WIDTH) begin
         width_in = (COL_W+1)'(LINE_WIDTH);
      end else begin
         width_in = (COL_W+1)'(csr_wdata);
      end
      height_in = (csr_wdata == '0) ? DIM_W'(1) : csr_wdata;
   end

   assign s1_emits   = s1_pos_ff.row_ge1 && (s1_pos_ff.col_ge1 || s1_pos_ff.col_last);
   assign s1_go      = s1_valid_ff && (!s1_emits || !q_full);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_acc    = req_tvalid && req_tready;
   assign q_push     = s1_go && s1_emits;

   always_comb begin
      rd_entry = byp_ff ? byp_data_ff : rd_ff;
      cb       = s1_pos_ff.flush ? '0 : s1_pix_ff;
      ca       = s1_pos_ff.row_ge2 ? rd_entry.above : '0;
      wr_entry.mid   = cb;
      wr_entry.above = rd_entry.mid;

      q_item.br        = cb;
      q_item.ar        = ca;
      q_item.bl        = s1_pos_ff.col_ge2 ? bw0_ff : '0;
      q_item.bc        = s1_pos_ff.col_ge1 ? bw1_ff : '0;
      q_item.al        = (s1_pos_ff.col_ge2 && s1_pos_ff.row_ge2) ? aw0_ff : '0;
      q_item.ac        = (s1_pos_ff.col_ge1 && s1_pos_ff.row_ge2) ? aw1_ff : '0;
      q_item.emit_mid  = s1_pos_ff.row_ge1 && s1_pos_ff.col_ge1;
      q_item.emit_end  = s1_pos_ff.row_ge1 && s1_pos_ff.col_last;
      q_item.end_frame = s1_pos_ff.flush && s1_pos_ff.col_last;
   end

   // control: registers, raster position, stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= (COL_W+1)'(WIDTH_RESET);
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  width_ff  <= width_in;
               CSR_IMAGE_HEIGHT: height_ff <= height_in;
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_acc) begin
            if (pos_in.col_last) begin
               col_ff <= '0;
               row_ff <= pos_in.flush ? '0 : row_ff + DIM_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   // stage 1 payload and line store read, with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pix_ff   <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_pos_ff   <= pos_in;
         rd_ff       <= line_mem[col_ff];
         byp_ff      <= s1_go && (s1_col_ff == col_ff);
         byp_data_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_col_ff] <= wr_entry;
      end
   end

   // advance the horizontal windows
   always_ff @(posedge clock) begin
      if (s1_go) begin
         bw0_ff <= bw1_ff;
         bw1_ff <= cb;
         aw0_ff <= aw1_ff;
         aw1_ff <= ca;
      end
   end

endmodule

// ===== sv/vsef_queue.sv =====
// ----------------------------------------------------------------------------
// vsef_queue: short work queue between front and back
// Register-based FIFO of neighborhood words; decouples pixel intake from
// result output.
// ----------------------------------------------------------------------------
module vsef_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  vsef_pkg::work_item_type   push_item,
   input  logic                      push,
   output logic                      full,
   output vsef_pkg::work_item_type   head_item,
   output logic                      head_valid,
   input  logic                      pop
);
   import vsef_pkg::*;

   work_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/vsef_back.sv =====
// ----------------------------------------------------------------------------
// vsef_back: gradient and result output
// Takes neighborhood words from the queue, emits one or two clamped
// gradients per word through a registered output stage.
// ----------------------------------------------------------------------------
module vsef_back (
   input  logic                          clock,
   input  logic                          reset,
   input  vsef_pkg::work_item_type       head_item,
   input  logic                          head_valid,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [vsef_pkg::PIX_W-1:0]    rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);
   import vsef_pkg::*;

   logic             phase_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic [1:0]       rsp_user_ff;
   logic             rsp_last_ff;

   logic             load;
   logic             do_mid;
   logic [PIX_W-1:0] grad_in;
   logic [1:0]       user_in;
   logic             last_in;

   assign load   = head_valid && (!rsp_valid_ff || rsp_tready);
   assign do_mid = !phase_ff && head_item.emit_mid;
   assign pop    = load && !(do_mid && head_item.emit_end);

   always_comb begin
      if (do_mid) begin
         grad_in = sobel_grad(head_item.al, head_item.ac, head_item.ar,
                              head_item.bl, head_item.bc, head_item.br);
         user_in = 2'b00;
         last_in = !head_item.emit_end;
      end else begin
         grad_in = sobel_grad(head_item.ac, head_item.ar, '0,
                              head_item.bc, head_item.br, '0);
         user_in = {head_item.end_frame, 1'b1};
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff     <= do_mid && head_item.emit_end;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= grad_in;
         rsp_user_ff <= user_in;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/vertical_sobel_edge_filter_core.sv =====
// ----------------------------------------------------------------------------
// vertical_sobel_edge_filter_core: streaming vertical 3x3 Sobel gradient
// Result word passes the stage 1 register, work queue and output register; end-of-row
// second word follows. Throughput: one pixel and one result word per cycle without stalls.
// Reset (synchronous): width and height 512, frame start, queue/output empty.
// ----------------------------------------------------------------------------
module vertical_sobel_edge_filter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [vsef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsef_pkg::DIM_W-1:0]      csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] pixel_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] edge_value
   output logic [1:0]                      rsp_tuser,   // [0] end_of_row, [1] end_of_frame
   output logic                            rsp_tlast    // last_of_run
);
   import vsef_pkg::*;

   work_item_type q_in_item;
   work_item_type q_head_item;
   logic          q_push;
   logic          q_full;
   logic          q_head_valid;
   logic          q_pop;

   vsef_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_item     (q_in_item),
      .q_push     (q_push),
      .q_full     (q_full)
   );

   vsef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (q_in_item),
      .push       (q_push),
      .full       (q_full),
      .head_item  (q_head_item),
      .head_valid (q_head_valid),
      .pop        (q_pop)
   );

   vsef_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (q_head_item),
      .head_valid (q_head_valid),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("work word pushed into a full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("work word popped from an empty queue");

   a_frame_end_closes_row : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tlast)
      else $error("end of frame without end of row and last of run");

   a_out_empty_after_reset : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result word valid right after reset");

endmodule

// ===== tb/sv/tb_vertical_sobel_edge_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_vertical_sobel_edge_filter_core: self-checking bench for the Sobel core
// Streams grey pixels through the core, predicts every clamped vertical
// gradient with its row, frame and run markers, and compares each result word
// as it leaves. Covers the reset geometry, tiny and clamped widths and
// heights, frame restarts on register writes, long output stalls that back
// up the input, and random frames under three idling mixes.
// ----------------------------------------------------------------------------
module tb_vertical_sobel_edge_filter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import vsef_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 20;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             row_end;
      logic             frame_end;
      logic             run_last;
   } gradient_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]     csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;      // [7:0] pixel_value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;           // [7:0] edge_value
   logic [1:0]           rsp_tuser;           // [0] end_of_row, [1] end_of_frame
   logic                 rsp_tlast;

   // filter image held by the predictor
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [7:0]       above_line [LINE_WIDTH];
   logic [7:0]       middle_line [LINE_WIDTH];
   logic [7:0]       below_win [2];
   logic [7:0]       above_win [2];
   int               col_pos;
   int               row_pos;

   gradient_word_type gradient_queue [$];
   gradient_word_type observed_word;
   gradient_word_type predicted_word;

   int send_idle_pct = 18;
   int rsp_idle_pct  = 63;
   int rsp_hold_left = 0;
   int flat_level    = 128;
   int error_count   = 0;
   int pixels_sent   = 0;
   int words_checked = 0;
   int register_writes = 0;
   int quiet_cycles  = 0;

   vertical_sobel_edge_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] clamp_gradient(input int below_sum, input int above_sum);
      int diff;
      diff = below_sum - above_sum;
      if (diff < 0) return 8'd0;
      if (diff > int'(PIXEL_MAX)) return PIXEL_MAX;
      return diff[7:0];
   endfunction

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'hFF;
         2, 3: return 8'($urandom_range(255));
         default: return 8'(flat_level + $urandom_range(15));
      endcase
   endfunction

   task automatic clear_filter();
      cfg_width  = DIM_W'(WIDTH_RESET);
      cfg_height = HEIGHT_RESET;
      foreach (above_line[i]) above_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      below_win = '{8'd0, 8'd0};
      above_win = '{8'd0, 8'd0};
      col_pos = 0;
      row_pos = 0;
   endtask

   // advance the filter by one pixel and queue the gradients it releases
   task automatic advance_filter(input logic [7:0] pix);
      int w, h, c, r, cb, ca, bl, bc, al, ac, n;
      gradient_word_type run [2];
      n = 0;
      w = (cfg_width == 0) ? 1 : (cfg_width > LINE_WIDTH) ? LINE_WIDTH : int'(cfg_width);
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos > h) ? 0 : row_pos;
      cb = (r == h) ? 0 : int'(pix);
      ca = (r >= 2) ? int'(above_line[c]) : 0;
      bl = (c >= 2) ? int'(below_win[0]) : 0;
      bc = (c >= 1) ? int'(below_win[1]) : 0;
      al = (c >= 2 && r >= 2) ? int'(above_win[0]) : 0;
      ac = (c >= 1 && r >= 2) ? int'(above_win[1]) : 0;
      if (r >= 1) begin
         if (c >= 1) begin
            run[n] = '{clamp_gradient(bl + 2 * bc + cb, al + 2 * ac + ca), 1'b0, 1'b0, 1'b0};
            n++;
         end
         if (c + 1 == w) begin
            run[n] = '{clamp_gradient(bc + 2 * cb, ac + 2 * ca), 1'b1, r == h, 1'b0};
            n++;
         end
         if (n > 0) run[n - 1].run_last = 1'b1;
         for (int k = 0; k < n; k++) gradient_queue.push_back(run[k]);
      end
      above_line[c]  = middle_line[c];
      middle_line[c] = cb[7:0];
      below_win[0]   = below_win[1];
      below_win[1]   = cb[7:0];
      above_win[0]   = above_win[1];
      above_win[1]   = ca[7:0];
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r > h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic send_pixel(input logic [7:0] pix);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      advance_filter(pix);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel());
   endtask

   // drop valid, drain every queued gradient, then let the pipeline go quiet
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (gradient_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      col_pos = 0;
      row_pos = 0;
      register_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
      settle_idle();
      write_register(CSR_IMAGE_WIDTH, width);
      write_register(CSR_IMAGE_HEIGHT, height);
      flat_level = $urandom_range(240);
   endtask

   task automatic test_default_geometry();
      send_random(2 * 512 + 12);
   endtask

   task automatic test_corner_frames();
      configure(10'd1, 10'd1);
      send_pixel(8'hFF); send_pixel(8'd77);
      configure(10'd0, 10'd0);
      send_pixel(8'd200); send_pixel(8'd13);
      configure(10'd1, 10'd3);
      send_pixel(8'd0); send_pixel(8'hFF); send_pixel(8'd0); send_pixel(8'hFF);
      configure(10'd2, 10'd2);
      send_pixel(8'hFF); send_pixel(8'hFF); send_pixel(8'd0); send_pixel(8'd0);
      send_pixel(8'd9); send_pixel(8'd9);
      configure(10'd3, 10'd2);
      send_pixel(8'd0); send_pixel(8'd128); send_pixel(8'hFF);
      send_pixel(8'hFF); send_pixel(8'd1); send_pixel(8'd0);
      send_pixel(8'd3); send_pixel(8'd200); send_pixel(8'd17);
   endtask

   task automatic test_width_clamp();
      configure(10'd1023, 10'd0);
      send_random(512 + 12);
   endtask

   task automatic test_backpressure();
      configure(10'd8, 10'd4);
      @(posedge clock);
      rsp_hold_left = HOLD_CYCLES;
      send_random(2 * 8 * 5);
   endtask

   task automatic test_random_geometry(input int count);
      int start, w, h, weff, heff, n;
      start = pixels_sent;
      while (pixels_sent - start < count) begin
         if ($urandom_range(99) < 80) begin
            w = $urandom_range(12, 1);
         end else begin
            case ($urandom_range(5))
               0: w = 0;
               1: w = 2;
               2: w = 511;
               3: w = 512;
               4: w = 513;
               default: w = 1023;
            endcase
         end
         h = ($urandom_range(99) < 85) ? $urandom_range(6) : (($urandom_range(1) != 0) ? 1023 : 511);
         weff = (w == 0) ? 1 : (w > LINE_WIDTH) ? LINE_WIDTH : w;
         heff = (h == 0) ? 1 : h;
         if (weff <= 16 && heff <= 8) begin
            n = $urandom_range(2, 1) * weff * (heff + 1);
            if ($urandom_range(1) != 0) n += $urandom_range(2 * weff);
         end else begin
            n = $urandom_range(40, 5);
         end
         configure(DIM_W'(w), DIM_W'(h));
         send_random(n);
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed_word = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast};
         if (gradient_queue.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t unexpected word: expected none, actual %h", $time, observed_word);
         end else begin
            predicted_word = gradient_queue.pop_front();
            words_checked++;
            if (observed_word !== predicted_word) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t mismatch: expected edge %h eor %b eof %b last %b, actual edge %h eor %b eof %b last %b",
                           $time, predicted_word.magnitude, predicted_word.row_end,
                           predicted_word.frame_end, predicted_word.run_last,
                           observed_word.magnitude, observed_word.row_end,
                           observed_word.frame_end, observed_word.run_last);
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL vertical_sobel_edge_filter_core");
      $finish;
   end

   initial begin
      clear_filter();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      rsp_idle_pct  = 63;
      test_default_geometry();
      test_corner_frames();
      test_width_clamp();
      test_random_geometry(40);

      send_idle_pct = 63;
      rsp_idle_pct  = 18;
      test_backpressure();
      test_random_geometry(40);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_geometry(40);

      settle_idle();
      $display("Streamed %0d pixels and checked %0d gradient words over %0d register writes,",
               pixels_sent, words_checked, register_writes);
      $display("including reset geometry, clamped sizes, mid-frame restarts and a long output stall.");
      if (error_count == 0) begin
         $display("PASS vertical_sobel_edge_filter_core");
      end else begin
         $display("%0d errors", error_count);
         $display("FAIL vertical_sobel_edge_filter_core");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/vsef_pkg.sv
sv/vsef_front.sv
sv/vsef_queue.sv
sv/vsef_back.sv
sv/vertical_sobel_edge_filter_core.sv
tb/sv/tb_vertical_sobel_edge_filter_core.sv
